// ===== sv/sst_pkg.sv =====
// Package for the sparse-set handle table: sizes, codes, controller states
// and the command and status bundles between controller and datapath.
// Depends on nothing; every other file of the block imports it.
package sst_pkg;

   localparam int CAPACITY = 128;
   localparam int HANDLE_W = $clog2(CAPACITY);
   localparam int COUNT_W  = HANDLE_W + 1;
   localparam int WORD_W   = 32;
   localparam int ENTRY_W  = 4 * WORD_W;

   // Marker for "no handle": an empty free list, and the end of its links in the map.
   localparam logic [COUNT_W-1:0] NO_LINK   = '1;
   localparam logic [COUNT_W-1:0] CAP_COUNT = COUNT_W'(CAPACITY);

   localparam logic [1:0] MODE_CREATE  = 2'd0;
   localparam logic [1:0] MODE_DESTROY = 2'd1;
   localparam logic [1:0] MODE_GET     = 2'd2;
   localparam logic [1:0] MODE_SLOT    = 2'd3;

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_FULL     = 2'd1;
   localparam logic [1:0] STATUS_NOT_LIVE = 2'd2;
   localparam logic [1:0] STATUS_BEYOND   = 2'd3;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CRT_COMMIT,
      ST_CRT_FULL,
      ST_DST_OWNER,
      ST_DST_MOVE,
      ST_DST_LINK,
      ST_GET_READ,
      ST_GET_RESP,
      ST_SLOT_RESP
   } state_type;

   typedef enum logic [2:0] {
      RK_CREATED,
      RK_FULL,
      RK_NOT_LIVE,
      RK_DESTROYED,
      RK_GET,
      RK_SLOT,
      RK_BEYOND
   } resp_kind_type;

   typedef struct packed {
      logic          accept;
      logic          crt_dense_wr;
      logic          crt_commit;
      logic          owner_rd_d;
      logic          payload_rd_d;
      logic          dst_move;
      logic          dst_link;
      logic          resp;
      resp_kind_type resp_kind;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic live_ok;
      logic slot_ok;
   } stat_type;

endpackage

// ===== sv/sparse_set_handle_table.sv =====
// Sparse-set handle table, top level. States per operation: create commit (or
// full); read-slot respond; get read, respond; destroy owner read, move, link
// (ending at move if the handle is not live), as the sparse-map then dense-owner
// reads depend on each other. busy stays high until the result beat, so the
// next operation may start in the cycle the result is shown. Synchronous reset
// empties the table at once; results cannot be stalled by the receiver.
module sparse_set_handle_table (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [1:0]                    req_mode,
   input  logic [sst_pkg::HANDLE_W-1:0]  req_handle,
   input  logic [sst_pkg::HANDLE_W-1:0]  req_slot_index,
   input  logic [sst_pkg::WORD_W-1:0]    req_pos_x,
   input  logic [sst_pkg::WORD_W-1:0]    req_pos_y,
   input  logic [sst_pkg::WORD_W-1:0]    req_size_x,
   input  logic [sst_pkg::WORD_W-1:0]    req_size_y,
   output logic                          rsp_valid,
   output logic [1:0]                    rsp_status,
   output logic [sst_pkg::HANDLE_W-1:0]  rsp_out_handle,
   output logic [sst_pkg::WORD_W-1:0]    rsp_out_pos_x,
   output logic [sst_pkg::WORD_W-1:0]    rsp_out_pos_y,
   output logic [sst_pkg::WORD_W-1:0]    rsp_out_size_x,
   output logic [sst_pkg::WORD_W-1:0]    rsp_out_size_y,
   output logic [sst_pkg::COUNT_W-1:0]   rsp_live_count_out
);
   import sst_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   sst_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_mode (req_mode),
      .stat     (stat),
      .cmd      (cmd),
      .busy     (busy)
   );

   sst_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .stat               (stat),
      .req_mode           (req_mode),
      .req_handle         (req_handle),
      .req_slot_index     (req_slot_index),
      .req_pos_x          (req_pos_x),
      .req_pos_y          (req_pos_y),
      .req_size_x         (req_size_x),
      .req_size_y         (req_size_y),
      .rsp_valid          (rsp_valid),
      .rsp_status         (rsp_status),
      .rsp_out_handle     (rsp_out_handle),
      .rsp_out_pos_x      (rsp_out_pos_x),
      .rsp_out_pos_y      (rsp_out_pos_y),
      .rsp_out_size_x     (rsp_out_size_x),
      .rsp_out_size_y     (rsp_out_size_y),
      .rsp_live_count_out (rsp_live_count_out)
   );

endmodule

// ===== sv/sst_ctrl.sv =====
// Controller of the sparse-set handle table: sequences the memory reads and
// writes of each operation and picks the response.
// Depends on sst_pkg.
module sst_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [1:0]        req_mode,
   input  sst_pkg::stat_type stat,
   output sst_pkg::cmd_type  cmd,
   output logic              busy
);
   import sst_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               case (req_mode)
                  MODE_CREATE:  state_in = stat.full ? ST_CRT_FULL : ST_CRT_COMMIT;
                  MODE_DESTROY: state_in = ST_DST_OWNER;
                  MODE_GET:     state_in = ST_GET_READ;
                  default:      state_in = ST_SLOT_RESP;
               endcase
            end
         end
         ST_DST_OWNER: state_in = ST_DST_MOVE;
         ST_DST_MOVE:  state_in = stat.live_ok ? ST_DST_LINK : ST_IDLE;
         ST_GET_READ:  state_in = ST_GET_RESP;
         default:      state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      cmd.resp_kind = RK_CREATED;
      case (state_ff)
         ST_IDLE: begin
            cmd.accept       = start;
            cmd.crt_dense_wr = start && (req_mode == MODE_CREATE) && !stat.full;
         end
         ST_CRT_COMMIT: begin
            cmd.crt_commit = 1'b1;
            cmd.resp       = 1'b1;
            cmd.resp_kind  = RK_CREATED;
         end
         ST_CRT_FULL: begin
            cmd.resp      = 1'b1;
            cmd.resp_kind = RK_FULL;
         end
         ST_DST_OWNER: begin
            cmd.owner_rd_d = 1'b1;
         end
         ST_DST_MOVE: begin
            // A handle that is not live ends the beat here with an error.
            cmd.dst_move  = stat.live_ok;
            cmd.resp      = !stat.live_ok;
            cmd.resp_kind = RK_NOT_LIVE;
         end
         ST_DST_LINK: begin
            cmd.dst_link  = 1'b1;
            cmd.resp      = 1'b1;
            cmd.resp_kind = RK_DESTROYED;
         end
         ST_GET_READ: begin
            cmd.owner_rd_d   = 1'b1;
            cmd.payload_rd_d = 1'b1;
         end
         ST_GET_RESP: begin
            cmd.resp      = 1'b1;
            cmd.resp_kind = stat.live_ok ? RK_GET : RK_NOT_LIVE;
         end
         ST_SLOT_RESP: begin
            cmd.resp      = 1'b1;
            cmd.resp_kind = stat.slot_ok ? RK_SLOT : RK_BEYOND;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

// ===== sv/sst_datapath.sv =====
// Datapath of the sparse-set handle table: sparse map, dense owner and dense
// payload memories, allocation registers and the response register.
// Depends on sst_pkg; driven by commands from sst_ctrl.
module sst_datapath (
   input  logic                          clock,
   input  logic                          reset,
   input  sst_pkg::cmd_type              cmd,
   output sst_pkg::stat_type             stat,
   input  logic [1:0]                    req_mode,
   input  logic [sst_pkg::HANDLE_W-1:0]  req_handle,
   input  logic [sst_pkg::HANDLE_W-1:0]  req_slot_index,
   input  logic [sst_pkg::WORD_W-1:0]    req_pos_x,
   input  logic [sst_pkg::WORD_W-1:0]    req_pos_y,
   input  logic [sst_pkg::WORD_W-1:0]    req_size_x,
   input  logic [sst_pkg::WORD_W-1:0]    req_size_y,
   output logic                          rsp_valid,
   output logic [1:0]                    rsp_status,
   output logic [sst_pkg::HANDLE_W-1:0]  rsp_out_handle,
   output logic [sst_pkg::WORD_W-1:0]    rsp_out_pos_x,
   output logic [sst_pkg::WORD_W-1:0]    rsp_out_pos_y,
   output logic [sst_pkg::WORD_W-1:0]    rsp_out_size_x,
   output logic [sst_pkg::WORD_W-1:0]    rsp_out_size_y,
   output logic [sst_pkg::COUNT_W-1:0]   rsp_live_count_out
);
   import sst_pkg::*;

   // Map entries at or above high_water may be read, but their values are never used,
   // so the map needs no clearing: every entry whose value is used has been written.
   logic [COUNT_W-1:0]  sparse_mem  [CAPACITY];
   logic [HANDLE_W-1:0] owner_mem   [CAPACITY];
   logic [ENTRY_W-1:0]  payload_mem [CAPACITY];

   logic [COUNT_W-1:0]  sparse_rdata_ff;
   logic [HANDLE_W-1:0] owner_rdata_ff;
   logic [ENTRY_W-1:0]  payload_rdata_ff;

   logic [COUNT_W-1:0]  free_head_ff, free_head_in;
   logic [COUNT_W-1:0]  high_water_ff, high_water_in;
   logic [COUNT_W-1:0]  live_count_ff, live_count_in;

   logic [HANDLE_W-1:0] h_ff;
   logic [HANDLE_W-1:0] nh_ff;
   logic [HANDLE_W-1:0] mover_ff;
   logic                from_free_ff;
   logic                h_lt_hw_ff;
   logic                slot_ok_ff;

   logic                rsp_valid_ff;
   logic [1:0]          rsp_status_ff, rsp_status_in;
   logic [HANDLE_W-1:0] rsp_handle_ff, rsp_handle_in;
   logic [ENTRY_W-1:0]  rsp_entry_ff, rsp_entry_in;
   logic [COUNT_W-1:0]  rsp_count_ff;

   logic                fh_valid;
   logic [HANDLE_W-1:0] nh;
   logic [COUNT_W-1:0]  live_dec;
   logic [HANDLE_W-1:0] last_idx;

   logic [HANDLE_W-1:0] sparse_raddr;
   logic                sparse_we;
   logic [HANDLE_W-1:0] sparse_waddr;
   logic [COUNT_W-1:0]  sparse_wdata;
   logic                owner_re;
   logic [HANDLE_W-1:0] owner_raddr;
   logic                owner_we;
   logic [HANDLE_W-1:0] owner_waddr;
   logic [HANDLE_W-1:0] owner_wdata;
   logic                payload_re;
   logic [HANDLE_W-1:0] payload_raddr;
   logic [ENTRY_W-1:0]  payload_wdata;

   assign fh_valid = (free_head_ff != NO_LINK);
   assign nh       = fh_valid ? free_head_ff[HANDLE_W-1:0] : high_water_ff[HANDLE_W-1:0];
   assign live_dec = live_count_ff - COUNT_W'(1);
   assign last_idx = live_dec[HANDLE_W-1:0];

   assign stat.full    = !(fh_valid || (high_water_ff < CAP_COUNT)) ||
                         (live_count_ff == CAP_COUNT);
   // Valid once the map entry and then the owner at that slot have been read.
   assign stat.live_ok = h_lt_hw_ff && (sparse_rdata_ff < live_count_ff) &&
                         (owner_rdata_ff == h_ff);
   assign stat.slot_ok = slot_ok_ff;

   // Read and write address selection.
   always_comb begin
      sparse_raddr = (req_mode == MODE_CREATE) ? free_head_ff[HANDLE_W-1:0] : req_handle;

      owner_re    = cmd.accept || cmd.owner_rd_d;
      owner_raddr = cmd.owner_rd_d ? sparse_rdata_ff[HANDLE_W-1:0] :
                    ((req_mode == MODE_DESTROY) ? last_idx : req_slot_index);

      payload_re    = cmd.accept || cmd.payload_rd_d;
      payload_raddr = cmd.payload_rd_d ? sparse_rdata_ff[HANDLE_W-1:0] :
                      ((req_mode == MODE_DESTROY) ? last_idx : req_slot_index);

      sparse_we = cmd.crt_commit || cmd.dst_move || cmd.dst_link;
      if (cmd.crt_commit) begin
         sparse_waddr = nh_ff;
         sparse_wdata = live_count_ff;
      end else if (cmd.dst_move) begin
         sparse_waddr = mover_ff;
         sparse_wdata = sparse_rdata_ff;
      end else begin
         sparse_waddr = h_ff;
         sparse_wdata = free_head_ff;
      end

      owner_we = cmd.crt_dense_wr || cmd.dst_move;
      if (cmd.dst_move) begin
         owner_waddr   = sparse_rdata_ff[HANDLE_W-1:0];
         owner_wdata   = mover_ff;
         payload_wdata = payload_rdata_ff;
      end else begin
         owner_waddr   = live_count_ff[HANDLE_W-1:0];
         owner_wdata   = nh;
         payload_wdata = {req_size_y, req_size_x, req_pos_y, req_pos_x};
      end
   end

   always_ff @(posedge clock) begin
      if (sparse_we) begin
         sparse_mem[sparse_waddr] <= sparse_wdata;
      end
      if (cmd.accept) begin
         sparse_rdata_ff <= sparse_mem[sparse_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (owner_we) begin
         owner_mem[owner_waddr] <= owner_wdata;
      end
      if (owner_re) begin
         owner_rdata_ff <= owner_mem[owner_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (owner_we) begin
         payload_mem[owner_waddr] <= payload_wdata;
      end
      if (payload_re) begin
         payload_rdata_ff <= payload_mem[payload_raddr];
      end
   end

   // Request fields kept for the later steps of an operation.
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         h_ff         <= req_handle;
         nh_ff        <= nh;
         from_free_ff <= fh_valid;
         h_lt_hw_ff   <= (COUNT_W'(req_handle) < high_water_ff);
         slot_ok_ff   <= (COUNT_W'(req_slot_index) < live_count_ff);
      end
      // The first owner read of a destroy fetched the last slot's owner.
      if (cmd.owner_rd_d) begin
         mover_ff <= owner_rdata_ff;
      end
   end

   always_comb begin
      free_head_in  = free_head_ff;
      high_water_in = high_water_ff;
      live_count_in = live_count_ff;
      if (cmd.crt_commit) begin
         live_count_in = live_count_ff + COUNT_W'(1);
         if (from_free_ff) begin
            free_head_in = sparse_rdata_ff;
         end else begin
            high_water_in = high_water_ff + COUNT_W'(1);
         end
      end else if (cmd.dst_link) begin
         free_head_in  = COUNT_W'(h_ff);
         live_count_in = live_dec;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         free_head_ff  <= NO_LINK;
         high_water_ff <= '0;
         live_count_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         free_head_ff  <= free_head_in;
         high_water_ff <= high_water_in;
         live_count_ff <= live_count_in;
         rsp_valid_ff  <= cmd.resp;
      end
   end

   always_comb begin
      rsp_status_in = STATUS_OK;
      rsp_handle_in = '0;
      rsp_entry_in  = '0;
      case (cmd.resp_kind)
         RK_CREATED:   rsp_handle_in = nh_ff;
         RK_FULL:      rsp_status_in = STATUS_FULL;
         RK_NOT_LIVE:  rsp_status_in = STATUS_NOT_LIVE;
         RK_DESTROYED: rsp_status_in = STATUS_OK;
         RK_GET: begin
            rsp_handle_in = h_ff;
            rsp_entry_in  = payload_rdata_ff;
         end
         RK_SLOT: begin
            rsp_handle_in = owner_rdata_ff;
            rsp_entry_in  = payload_rdata_ff;
         end
         default:      rsp_status_in = STATUS_BEYOND;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.resp) begin
         rsp_count_ff  <= live_count_in;
         rsp_status_ff <= rsp_status_in;
         rsp_handle_ff <= rsp_handle_in;
         rsp_entry_ff  <= rsp_entry_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_out_handle     = rsp_handle_ff;
   assign rsp_out_pos_x      = rsp_entry_ff[WORD_W-1:0];
   assign rsp_out_pos_y      = rsp_entry_ff[2*WORD_W-1:WORD_W];
   assign rsp_out_size_x     = rsp_entry_ff[3*WORD_W-1:2*WORD_W];
   assign rsp_out_size_y     = rsp_entry_ff[4*WORD_W-1:3*WORD_W];
   assign rsp_live_count_out = rsp_count_ff;

   a_live_le_hw: assert property (@(posedge clock) disable iff (reset)
      live_count_ff <= high_water_ff)
      else $error("live count exceeds handles handed out");

   a_hw_le_cap: assert property (@(posedge clock) disable iff (reset)
      high_water_ff <= CAP_COUNT)
      else $error("high water mark beyond capacity");

   a_free_head: assert property (@(posedge clock) disable iff (reset)
      (free_head_ff == NO_LINK) || (free_head_ff < high_water_ff))
      else $error("free list head is not a handed-out handle");

   a_link_nonempty: assert property (@(posedge clock) disable iff (reset)
      cmd.dst_link |-> (live_count_ff != '0) && $past(cmd.dst_move))
      else $error("free list link without a preceding relocation");

endmodule
